// ----- rtl/lcdnw_pkg.sv -----
// Package for the character LCD nibble writer: request kinds, settle codes,
// the nibble record type and the byte/address helper functions. No dependencies.
package lcdnw_pkg;

   localparam int RUN_MAX = 14;
   localparam int CNT_W   = 4;

   localparam logic [2:0] KIND_INIT    = 3'd0;
   localparam logic [2:0] KIND_CLEAR   = 3'd1;
   localparam logic [2:0] KIND_SET_CUR = 3'd2;
   localparam logic [2:0] KIND_PRINT_T = 3'd3;
   localparam logic [2:0] KIND_PRINT_U = 3'd4;
   localparam logic [2:0] KIND_PRINT_AT= 3'd5;

   localparam logic [1:0] SETTLE_NONE = 2'd0;
   localparam logic [1:0] SETTLE_40US = 2'd1;
   localparam logic [1:0] SETTLE_2MS  = 2'd2;
   localparam logic [1:0] SETTLE_5MS  = 2'd3;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   localparam logic [0:0] CSR_ROWS = 1'b0;
   localparam logic [0:0] CSR_COLS = 1'b1;

   localparam logic [2:0] ROWS_RESET = 3'd4;
   localparam logic [5:0] COLS_RESET = 6'd20;

   typedef struct packed {
      logic       rs;
      logic [3:0] nib;
      logic [1:0] settle;
   } nib_type;

   typedef nib_type run_type [RUN_MAX];

   function automatic nib_type mk_nib(logic rs, logic [3:0] nib, logic [1:0] settle);
      nib_type n;
      n.rs     = rs;
      n.nib    = nib;
      n.settle = settle;
      return n;
   endfunction

   // high nibble of a byte never waits
   function automatic nib_type byte_hi(logic rs, logic [7:0] b);
      return mk_nib(rs, b[7:4], SETTLE_NONE);
   endfunction

   function automatic nib_type byte_lo(logic rs, logic [7:0] b, logic [1:0] settle);
      return mk_nib(rs, b[3:0], settle);
   endfunction

   function automatic logic [6:0] row_base(logic [1:0] row);
      logic [6:0] b;
      unique case (row)
         2'd0:    b = 7'h00;
         2'd1:    b = 7'h40;
         2'd2:    b = 7'h14;
         default: b = 7'h54;
      endcase
      return b;
   endfunction

   // set-DDRAM-address command; column is 7-bit two's complement
   function automatic logic [7:0] addr_cmd(logic [1:0] row, logic [6:0] col);
      logic [6:0] a;
      a = row_base(row) + col;
      return {1'b1, a};
   endfunction

endpackage

// ----- rtl/char_lcd_nibble_writer_core.sv -----
// Character LCD nibble writer, top level: request decode, cursor tracking,
// nibble run buffer and result register. Depends on lcdnw_pkg.
//
// An accepted request fills the run buffer; each nibble then moves to the result register for rsp_*.
// Throughput: one nibble per cycle while rsp_stall does not hold the result register; a
//   request producing 2 to 14 nibbles holds the run buffer, and the next request is taken
//   as its last nibble moves out. Requests of an unused kind produce nothing.
// Reset: synchronous, clears cursor to row 0 / column 0, rows_in_use to 4,
//   cols_in_use to 20, and empties the run buffer and result register.
module char_lcd_nibble_writer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [0:0] csr_index,
   input  logic [5:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_char_code,
   input  logic [1:0] req_row,
   input  logic [5:0] req_col,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_reg_select,
   output logic [3:0] rsp_nibble,
   output logic [1:0] rsp_settle,
   output logic       rsp_last
);
   import lcdnw_pkg::*;

   // configuration
   logic [2:0] rows_ff;
   logic [5:0] cols_ff;

   // tracked cursor; column -1 means "before column 0" after a clear
   logic [1:0] cur_row_ff, cur_row_in;
   logic [6:0] cur_col_ff, cur_col_in;

   // run buffer: entry 0 is the next nibble to go out, shifts down as they leave
   run_type          run_ff, run_in, run_new;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_new;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   nib_type    rsp_nib_ff, rsp_nib_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       out_free;
   logic       emit;
   logic       accept;

   // wrap decisions
   logic       row_lt;
   logic       col_lt;
   logic [1:0] wrap_row;
   logic [7:0] wrap_addr;
   logic [7:0] req_addr;
   logic [7:0] cur_addr;

   // ------------------------------------------------------------------
   // Handshake. The result register frees when empty or being taken; the
   // run buffer can take a new request when empty or once its last nibble is moving out.
   // ------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = (cnt_ff != '0) && out_free;
   assign req_stall = (cnt_ff != '0) && !(emit && cnt_ff == CNT_W'(1));
   assign accept    = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // Cursor wrap logic (signed compares as in the display driver:
   // rows_in_use of 0 always wraps, column -1 is below any cols_in_use of 1 or more).
   // ------------------------------------------------------------------
   assign row_lt   = $signed({2'b00, cur_row_ff}) < $signed({1'b0, rows_ff} - 4'd1);
   assign col_lt   = $signed({cur_col_ff[6], cur_col_ff}) < $signed({2'b00, cols_ff} - 8'd1);
   assign wrap_row = row_lt ? cur_row_ff + 2'd1 : 2'd0;
   assign wrap_addr = addr_cmd(wrap_row, 7'd0);
   assign req_addr  = addr_cmd(req_row, {1'b0, req_col});
   assign cur_addr  = addr_cmd(cur_row_ff, cur_col_ff);

   // ------------------------------------------------------------------
   // Request decode: build the whole nibble run in one pass.
   // ------------------------------------------------------------------
   always_comb begin
      run_new    = '{default: '0};
      cnt_new    = '0;
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      unique case (req_kind)
         KIND_INIT: begin
            run_new[0]  = mk_nib(RS_CMD, 4'h3, SETTLE_5MS);
            run_new[1]  = mk_nib(RS_CMD, 4'h3, SETTLE_40US);
            run_new[2]  = mk_nib(RS_CMD, 4'h3, SETTLE_40US);
            run_new[3]  = mk_nib(RS_CMD, 4'h2, SETTLE_40US);
            run_new[4]  = byte_hi(RS_CMD, 8'h28);
            run_new[5]  = byte_lo(RS_CMD, 8'h28, SETTLE_40US);
            run_new[6]  = byte_hi(RS_CMD, 8'h08);
            run_new[7]  = byte_lo(RS_CMD, 8'h08, SETTLE_40US);
            run_new[8]  = byte_hi(RS_CMD, 8'h01);
            run_new[9]  = byte_lo(RS_CMD, 8'h01, SETTLE_2MS);
            run_new[10] = byte_hi(RS_CMD, 8'h06);
            run_new[11] = byte_lo(RS_CMD, 8'h06, SETTLE_40US);
            run_new[12] = byte_hi(RS_CMD, 8'h0E);
            run_new[13] = byte_lo(RS_CMD, 8'h0E, SETTLE_40US);
            cnt_new     = CNT_W'(14);
            cur_row_in  = 2'd0;
            cur_col_in  = 7'h7F;
         end
         KIND_CLEAR: begin
            run_new[0] = byte_hi(RS_CMD, 8'h01);
            run_new[1] = byte_lo(RS_CMD, 8'h01, SETTLE_2MS);
            cnt_new    = CNT_W'(2);
            cur_row_in = 2'd0;
            cur_col_in = 7'h7F;
         end
         KIND_SET_CUR: begin
            run_new[0] = byte_hi(RS_CMD, req_addr);
            run_new[1] = byte_lo(RS_CMD, req_addr, SETTLE_40US);
            cnt_new    = CNT_W'(2);
            cur_row_in = req_row;
            cur_col_in = {1'b0, req_col};
         end
         KIND_PRINT_T: begin
            if (req_char_code == CHAR_NEWLINE) begin
               run_new[0] = byte_hi(RS_CMD, wrap_addr);
               run_new[1] = byte_lo(RS_CMD, wrap_addr, SETTLE_40US);
               cnt_new    = CNT_W'(2);
               cur_row_in = wrap_row;
               cur_col_in = 7'd0;
            end else if (col_lt) begin
               run_new[0] = byte_hi(RS_DATA, req_char_code);
               run_new[1] = byte_lo(RS_DATA, req_char_code, SETTLE_40US);
               cnt_new    = CNT_W'(2);
               cur_col_in = cur_col_ff + 7'd1;
            end else begin
               // past the last column: move to next row, address, then the char
               run_new[0] = byte_hi(RS_CMD, wrap_addr);
               run_new[1] = byte_lo(RS_CMD, wrap_addr, SETTLE_40US);
               run_new[2] = byte_hi(RS_DATA, req_char_code);
               run_new[3] = byte_lo(RS_DATA, req_char_code, SETTLE_40US);
               cnt_new    = CNT_W'(4);
               cur_row_in = wrap_row;
               cur_col_in = 7'd0;
            end
         end
         KIND_PRINT_U: begin
            run_new[0] = byte_hi(RS_DATA, req_char_code);
            run_new[1] = byte_lo(RS_DATA, req_char_code, SETTLE_40US);
            cnt_new    = CNT_W'(2);
         end
         KIND_PRINT_AT: begin
            // jump, print, then restore the tracked cursor position
            run_new[0] = byte_hi(RS_CMD, req_addr);
            run_new[1] = byte_lo(RS_CMD, req_addr, SETTLE_40US);
            run_new[2] = byte_hi(RS_DATA, req_char_code);
            run_new[3] = byte_lo(RS_DATA, req_char_code, SETTLE_40US);
            run_new[4] = byte_hi(RS_CMD, cur_addr);
            run_new[5] = byte_lo(RS_CMD, cur_addr, SETTLE_40US);
            cnt_new    = CNT_W'(6);
         end
         default: begin
            // unused kinds: nothing emitted, cursor kept
            cnt_new = '0;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Run buffer and result register next state
   // ------------------------------------------------------------------
   always_comb begin
      run_in       = run_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_nib_in   = rsp_nib_ff;
      rsp_last_in  = rsp_last_ff;

      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_nib_in   = run_ff[0];
         rsp_last_in  = (cnt_ff == CNT_W'(1));
         for (int i = 0; i < RUN_MAX - 1; i++) begin
            run_in[i] = run_ff[i + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (accept) begin
         run_in = run_new;
         cnt_in = cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ROWS_RESET;
         cols_ff      <= COLS_RESET;
         cur_row_ff   <= 2'd0;
         cur_col_ff   <= 7'd0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ROWS: rows_ff <= csr_wdata[2:0];
               CSR_COLS: cols_ff <= csr_wdata;
               default:  rows_ff <= rows_ff;
            endcase
         end
         if (accept) begin
            cur_row_ff <= cur_row_in;
            cur_col_ff <= cur_col_in;
         end
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      rsp_nib_ff  <= rsp_nib_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reg_select = rsp_nib_ff.rs;
   assign rsp_nibble     = rsp_nib_ff.nib;
   assign rsp_settle     = rsp_nib_ff.settle;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- tb/sv/char_lcd_nibble_writer_core_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_nibble_writer_core: queued driver, clocked monitor and
// an in-bench cursor/nibble predictor. Depends on lcdnw_pkg and the core RTL.
module char_lcd_nibble_writer_core_tb;
   import lcdnw_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int QUIET_CYCLES = 4;   // quiet time the driver waits out before register writes and drain points
   localparam int TAIL_CYCLES  = 20;

   // kinds the core decodes as no-ops
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   // HD44780 bytes and nibbles used by the init run
   localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
   localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;
   localparam logic [7:0] CMD_FUNC_4BIT   = 8'h28;
   localparam logic [7:0] CMD_DISP_OFF    = 8'h08;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE  = 8'h06;
   localparam logic [7:0] CMD_DISP_ON     = 8'h0E;
   localparam logic [6:0] COL_HOME_LEFT   = 7'h7F;   // -1: next character lands on column 0

   typedef enum logic [1:0] {STEP_REQ, STEP_CSR, STEP_DRAIN} step_type;

   typedef struct packed {
      step_type   op;
      logic [1:0] phase;
      logic [2:0] kind;
      logic [7:0] char_code;
      logic [1:0] row;
      logic [5:0] col;
      logic [0:0] csr_idx;
      logic [5:0] csr_val;
   } lcd_cmd_type;

   typedef struct packed {
      logic       rs;
      logic [3:0] nib;
      logic [1:0] settle;
      logic       last;
   } lcd_write_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [0:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_kind = '0;
   logic [7:0] req_char_code = '0;
   logic [1:0] req_row = '0;
   logic [5:0] req_col = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_reg_select;
   logic [3:0] rsp_nibble;
   logic [1:0] rsp_settle;
   logic       rsp_last;

   lcd_cmd_type   cmd_backlog[$];     // requests, register writes and drain points, in order
   lcd_write_type lcd_writes_due[$];  // nibble writes predicted but not yet seen
   logic [1:0] build_phase;
   logic [1:0] idle_phase = 2'd0;
   int         mismatches = 0;
   int         quiet = 0;

   // predictor copy of cursor and register state
   logic [1:0] trk_row;
   logic [6:0] trk_col;            // two's complement
   logic [2:0] rows_setting;
   logic [5:0] cols_setting;
   lcd_write_type run_tail;        // held back until we know whether it ends the run
   logic       run_open = 1'b0;

   char_lcd_nibble_writer_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------
   function automatic void emit_nibble(logic rs, logic [3:0] nib, logic [1:0] settle);
      if (run_open)
         lcd_writes_due.push_back(run_tail);
      run_tail.rs     = rs;
      run_tail.nib    = nib;
      run_tail.settle = settle;
      run_tail.last   = 1'b0;
      run_open        = 1'b1;
   endfunction

   // high half never waits
   function automatic void emit_byte(logic rs, logic [7:0] b, logic [1:0] settle);
      emit_nibble(rs, b[7:4], SETTLE_NONE);
      emit_nibble(rs, b[3:0], settle);
   endfunction

   function automatic void emit_ddram_addr(logic [1:0] row, logic [6:0] col);
      logic [6:0] start;
      logic [6:0] addr;
      case (row)
         2'd0:    start = 7'h00;
         2'd1:    start = 7'h40;
         2'd2:    start = 7'h14;
         default: start = 7'h54;
      endcase
      addr = start + col;   // wraps mod 128, col -1 included
      emit_byte(RS_CMD, {1'b1, addr}, SETTLE_40US);
   endfunction

   function automatic void step_cursor_row();
      if (int'(trk_row) < int'(rows_setting) - 1)
         trk_row = trk_row + 2'd1;
      else
         trk_row = 2'd0;
      trk_col = 7'd0;
      emit_ddram_addr(trk_row, trk_col);
   endfunction

   function automatic void predict_lcd_writes(logic [2:0] kind, logic [7:0] ch,
                                              logic [1:0] row, logic [5:0] col);
      case (kind)
         KIND_INIT: begin
            emit_nibble(RS_CMD, WAKE_NIBBLE, SETTLE_5MS);
            emit_nibble(RS_CMD, WAKE_NIBBLE, SETTLE_40US);
            emit_nibble(RS_CMD, WAKE_NIBBLE, SETTLE_40US);
            emit_nibble(RS_CMD, BUS_4BIT_NIBBLE, SETTLE_40US);
            emit_byte(RS_CMD, CMD_FUNC_4BIT, SETTLE_40US);
            emit_byte(RS_CMD, CMD_DISP_OFF, SETTLE_40US);
            emit_byte(RS_CMD, CMD_CLEAR, SETTLE_2MS);
            emit_byte(RS_CMD, CMD_ENTRY_MODE, SETTLE_40US);
            emit_byte(RS_CMD, CMD_DISP_ON, SETTLE_40US);
            trk_row = 2'd0;
            trk_col = COL_HOME_LEFT;
         end
         KIND_CLEAR: begin
            emit_byte(RS_CMD, CMD_CLEAR, SETTLE_2MS);
            trk_row = 2'd0;
            trk_col = COL_HOME_LEFT;
         end
         KIND_SET_CUR: begin
            trk_row = row;
            trk_col = {1'b0, col};
            emit_ddram_addr(trk_row, trk_col);
         end
         KIND_PRINT_T: begin
            if (ch == CHAR_NEWLINE) begin
               step_cursor_row();
            end else begin
               // column moves first; past the last column goes to next row
               if ($signed(trk_col) < int'(cols_setting) - 1)
                  trk_col = trk_col + 7'd1;
               else
                  step_cursor_row();
               emit_byte(RS_DATA, ch, SETTLE_40US);
            end
         end
         KIND_PRINT_U: emit_byte(RS_DATA, ch, SETTLE_40US);
         KIND_PRINT_AT: begin
            emit_ddram_addr(row, {1'b0, col});
            emit_byte(RS_DATA, ch, SETTLE_40US);
            emit_ddram_addr(trk_row, trk_col);
         end
         default: ;
      endcase
      if (run_open) begin
         run_tail.last = 1'b1;
         lcd_writes_due.push_back(run_tail);
         run_open = 1'b0;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------------
   function automatic void add_req(logic [2:0] kind, logic [7:0] ch,
                                   logic [1:0] row, logic [5:0] col);
      lcd_cmd_type c;
      c = '0;
      c.op        = STEP_REQ;
      c.phase     = build_phase;
      c.kind      = kind;
      c.char_code = ch;
      c.row       = row;
      c.col       = col;
      cmd_backlog.push_back(c);
   endfunction

   // drain point first, so the write lands on an idle core
   function automatic void add_csr_pair(logic [2:0] rows, logic [5:0] cols);
      lcd_cmd_type c;
      c = '0;
      c.phase = build_phase;
      c.op    = STEP_DRAIN;
      cmd_backlog.push_back(c);
      c.op      = STEP_CSR;
      c.csr_idx = CSR_ROWS;
      c.csr_val = {3'd0, rows};
      cmd_backlog.push_back(c);
      c.csr_idx = CSR_COLS;
      c.csr_val = cols;
      cmd_backlog.push_back(c);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: unless stalled, one request or register write per cycle from the backlog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      logic        valid_nxt;
      logic        wr_nxt;
      logic        idle;
      lcd_cmd_type head;
      int          send_idle_pct;
      valid_nxt = req_valid;
      wr_nxt    = 1'b0;
      if (reset) begin
         valid_nxt    = 1'b0;
         trk_row      = 2'd0;
         trk_col      = 7'd0;
         rows_setting = ROWS_RESET;
         cols_setting = COLS_RESET;
         quiet        = 0;
      end else begin
         // quiet counts cycles with nothing in flight
         if (lcd_writes_due.size() == 0 && !req_valid)
            quiet++;
         else
            quiet = 0;
         idle = (quiet >= QUIET_CYCLES);

         if (req_valid && !req_stall) begin
            predict_lcd_writes(req_kind, req_char_code, req_row, req_col);
            void'(cmd_backlog.pop_front());
            valid_nxt = 1'b0;
         end

         if (!valid_nxt && cmd_backlog.size() > 0) begin
            head = cmd_backlog[0];
            idle_phase <= head.phase;
            send_idle_pct = (head.phase == 2'd0) ? 35 : (head.phase == 2'd1) ? 62 : 0;
            case (head.op)
               STEP_REQ: begin
                  if ($urandom_range(99) >= send_idle_pct) begin
                     valid_nxt = 1'b1;
                     req_kind      <= head.kind;
                     req_char_code <= head.char_code;
                     req_row       <= head.row;
                     req_col       <= head.col;
                  end
               end
               STEP_CSR: begin
                  if (idle) begin
                     wr_nxt = 1'b1;
                     csr_index <= head.csr_idx;
                     csr_wdata <= head.csr_val;
                     if (head.csr_idx == CSR_ROWS)
                        rows_setting = head.csr_val[2:0];
                     else
                        cols_setting = head.csr_val;
                     void'(cmd_backlog.pop_front());
                  end
               end
               default: begin
                  // hold off until every predicted nibble is out
                  if (idle)
                     void'(cmd_backlog.pop_front());
               end
            endcase
         end
      end
      req_valid <= valid_nxt;
      csr_wr_en <= wr_nxt;
   end

   // ---------------------------------------------------------------------------
   // Monitor: compare each accepted nibble with the oldest prediction
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      lcd_write_type got;
      lcd_write_type want;
      int            stall_pct;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.rs     = rsp_reg_select;
            got.nib    = rsp_nibble;
            got.settle = rsp_settle;
            got.last   = rsp_last;
            if (lcd_writes_due.size() == 0) begin
               $display("%0t: unexpected nibble write, expected none, actual %0h",
                        $time, got);
               mismatches++;
            end else begin
               want = lcd_writes_due.pop_front();
               check_field("reg_select", want.rs, got.rs);
               check_field("nibble", want.nib, got.nib);
               check_field("settle", want.settle, got.settle);
               check_field("last", want.last, got.last);
            end
         end
         stall_pct = (idle_phase == 2'd0) ? 62 : (idle_phase == 2'd1) ? 35 : 0;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------------
   // Run control
   // ---------------------------------------------------------------------------
   initial begin : run_limit
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      int          pick;
      logic [2:0]  kind;
      logic [7:0]  ch;
      logic [5:0]  cols;
      build_phase = 2'd0;

      // directed: reset cursor, init, clear, corner positions, spare kinds
      add_req(KIND_PRINT_T, 8'h41, 2'd0, 6'd0);       // from reset state, col 0
      add_req(KIND_INIT, 8'h00, 2'd0, 6'd0);
      add_req(KIND_CLEAR, 8'h00, 2'd0, 6'd0);
      add_req(KIND_SET_CUR, 8'h00, 2'd3, 6'd39);      // last row, last legal col
      add_req(KIND_PRINT_T, 8'hFF, 2'd0, 6'd0);       // column wrap + row wrap
      add_req(KIND_PRINT_T, CHAR_NEWLINE, 2'd0, 6'd0);
      add_req(KIND_PRINT_U, 8'h00, 2'd0, 6'd0);
      add_req(KIND_PRINT_U, CHAR_NEWLINE, 2'd0, 6'd0); // printed as a glyph
      add_req(KIND_PRINT_AT, 8'h7E, 2'd2, 6'd0);
      add_req(KIND_CLEAR, 8'h00, 2'd0, 6'd0);
      add_req(KIND_PRINT_AT, 8'h80, 2'd1, 6'd39);     // restore to col -1
      add_req(KIND_SPARE_6, 8'hAA, 2'd1, 6'd21);
      add_req(KIND_SPARE_7, 8'h55, 2'd2, 6'd42);
      add_req(KIND_SET_CUR, 8'h00, 2'd1, 6'd24);
      add_req(KIND_PRINT_T, 8'h5A, 2'd0, 6'd0);
      // smallest display: every character after the first wraps
      add_csr_pair(3'd1, 6'd1);
      add_req(KIND_CLEAR, 8'h00, 2'd0, 6'd0);
      add_req(KIND_PRINT_T, 8'h78, 2'd0, 6'd0);
      add_req(KIND_PRINT_T, 8'h79, 2'd0, 6'd0);
      add_req(KIND_PRINT_T, CHAR_NEWLINE, 2'd0, 6'd0);
      // largest display
      add_csr_pair(3'd4, 6'd40);
      add_req(KIND_SET_CUR, 8'h00, 2'd0, 6'd38);
      add_req(KIND_PRINT_T, 8'h31, 2'd0, 6'd0);
      add_req(KIND_PRINT_T, 8'h32, 2'd0, 6'd0);
      add_req(KIND_PRINT_T, 8'h33, 2'd0, 6'd0);
      add_req(KIND_PRINT_AT, 8'hC3, 2'd3, 6'd39);

      // random: nine segments, each request tracked text with even odds, new geometry per segment
      for (int seg = 0; seg < 9; seg++) begin
         build_phase = 2'(seg / 3);
         pick = $urandom_range(3);
         cols = (pick == 0) ? 6'd1 : (pick == 1) ? 6'd40 : 6'($urandom_range(1, 40));
         add_csr_pair(3'($urandom_range(1, 4)), cols);
         for (int n = 0; n < 10; n++) begin
            pick = $urandom_range(99);
            ch   = 8'($urandom_range(255));
            if (pick < 4)       kind = KIND_INIT;
            else if (pick < 10) kind = KIND_CLEAR;
            else if (pick < 20) kind = KIND_SET_CUR;
            else if (pick < 70) kind = KIND_PRINT_T;
            else if (pick < 80) kind = KIND_PRINT_U;
            else if (pick < 96) kind = KIND_PRINT_AT;
            else                kind = pick[0] ? KIND_SPARE_7 : KIND_SPARE_6;
            if (kind == KIND_PRINT_T && $urandom_range(99) < 15)
               ch = CHAR_NEWLINE;
            add_req(kind, ch, 2'($urandom_range(3)), 6'($urandom_range(39)));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (!(cmd_backlog.size() == 0 && !req_valid && lcd_writes_due.size() == 0))
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
